// ===== rtl/pbti_pkg.sv =====
// Shared types and constants of the periodic bilinear table interpolator.
package pbti_pkg;

   localparam int OUT_BITS = 24;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_LAYER   = 2'd1;
   localparam logic [1:0] ERR_ORBITAL = 2'd2;

   localparam logic [1:0] REG_GRID_X   = 2'd0;
   localparam logic [1:0] REG_GRID_Y   = 2'd1;
   localparam logic [1:0] REG_LAYERS   = 2'd2;
   localparam logic [1:0] REG_ORBITALS = 2'd3;

   localparam logic [2:0] LAYER_MIRROR = 3'd1;

   typedef struct packed {
      logic       valid;
      logic       neg;
      logic [1:0] err;
   } ctl_type;

endpackage

// ===== rtl/pbti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pbti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pbti_blend.sv =====
// Three-lane bilinear blend pipeline: weighting, rounding, negation and saturation.
module pbti_blend #(
   parameter int SB = 24,
   parameter int F  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pbti_pkg::ctl_type         in_ctl,
   input  logic [F-1:0]              fx,
   input  logic [F-1:0]              fy,
   input  logic [3*SB-1:0]           c00,
   input  logic [3*SB-1:0]           c10,
   input  logic [3*SB-1:0]           c01,
   input  logic [3*SB-1:0]           c11,
   output pbti_pkg::ctl_type         out_ctl,
   output logic [pbti_pkg::OUT_BITS-1:0] out_x,
   output logic [pbti_pkg::OUT_BITS-1:0] out_y,
   output logic [pbti_pkg::OUT_BITS-1:0] out_z
);

   localparam int AW = SB + F + 2;
   localparam int QW = AW - F;
   localparam int BW = QW + F + 2;
   localparam int TW = (BW + 1 > pbti_pkg::OUT_BITS + F + 1) ? BW + 1
                                                              : pbti_pkg::OUT_BITS + F + 1;
   localparam int VW = TW - F;
   localparam logic [TW-1:0] HALF = TW'(1) << (F - 1);
   localparam logic signed [VW-1:0] OMAX = VW'((64'sd1 <<< (pbti_pkg::OUT_BITS - 1)) - 1);
   localparam logic signed [VW-1:0] OMIN = VW'(-(64'sd1 <<< (pbti_pkg::OUT_BITS - 1)));

   logic signed [F+1:0] wx0, wx1, wy0, wy1;
   logic [F:0]          wy0_u;
   logic [F-1:0]        fy_ff;
   pbti_pkg::ctl_type   ctl_a_ff, ctl_b_ff, ctl_c_ff;
   logic [pbti_pkg::OUT_BITS-1:0] res_ff [3];

   assign wx1   = $signed({2'b00, fx});
   assign wx0   = $signed({1'b0, ({1'b1, {F{1'b0}}} - {1'b0, fx})});
   assign wy0_u = {1'b1, {F{1'b0}}} - {1'b0, fy_ff};
   assign wy0   = $signed({1'b0, wy0_u});
   assign wy1   = $signed({2'b00, fy_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
      fy_ff <= fy;
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      logic signed [SB-1:0] t00, t10, t01, t11;
      logic signed [AW-1:0] a0_in, a1_in, a0_ff, a1_ff;
      logic signed [QW-1:0] q0, q1;
      logic [2*F-1:0]       r_in;
      logic signed [BW-1:0] q_in, q_ff;
      logic [F-1:0]         rhi_ff;
      logic [TW-1:0]        t_sum;
      logic signed [VW-1:0] v, vn;
      logic [pbti_pkg::OUT_BITS-1:0] res_in;

      assign t00 = $signed(c00[k*SB +: SB]);
      assign t10 = $signed(c10[k*SB +: SB]);
      assign t01 = $signed(c01[k*SB +: SB]);
      assign t11 = $signed(c11[k*SB +: SB]);

      assign a0_in = t00 * wx0 + t10 * wx1;
      assign a1_in = t01 * wx0 + t11 * wx1;

      // Split each first-axis sum into its floor and remainder before the second axis.
      assign q0   = a0_ff[AW-1:F];
      assign q1   = a1_ff[AW-1:F];
      assign q_in = q0 * wy0 + q1 * wy1;
      assign r_in = a0_ff[F-1:0] * wy0_u + a1_ff[F-1:0] * fy_ff;

      assign t_sum = {{(TW-BW){q_ff[BW-1]}}, q_ff} + {{(TW-F){1'b0}}, rhi_ff} + HALF;
      assign v     = $signed(t_sum[TW-1:F]);
      assign vn    = ctl_b_ff.neg ? -v : v;

      always_comb begin
         if (ctl_b_ff.err != pbti_pkg::ERR_NONE) begin
            res_in = '0;
         end else if (vn > OMAX) begin
            res_in = OMAX[pbti_pkg::OUT_BITS-1:0];
         end else if (vn < OMIN) begin
            res_in = OMIN[pbti_pkg::OUT_BITS-1:0];
         end else begin
            res_in = vn[pbti_pkg::OUT_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         a0_ff     <= a0_in;
         a1_ff     <= a1_in;
         q_ff      <= q_in;
         rhi_ff    <= r_in[2*F-1:F];
         res_ff[k] <= res_in;
      end
   end

   assign out_ctl = ctl_c_ff;
   assign out_x   = res_ff[0];
   assign out_y   = res_ff[1];
   assign out_z   = res_ff[2];

endmodule

// ===== rtl/periodic_bilinear_table_interpolator_top.sv =====
// Top level of the periodic bilinear table interpolator.
//
// An item is taken at a rising edge where start is high and busy is low. With
// req_command at write it stores three samples at node (req_node_x, req_node_y)
// and gives no result. With req_command at query it looks up the four grid
// corners around (req_pos_a, req_pos_b) and returns the blended x, y and z
// displacements with an error code.
// One item is taken every cycle while busy is low. A query result is on the rsp_
// ports with rsp_valid high for one cycle: the accepting edge registers the item,
// the next edge reads the memory and the blend registers the first-axis sums, the
// second-axis sum and the saturated result in turn. Four copies of the grid
// memory, each written by every write item, give all four corners in the same
// cycle. A query after a write always sees that write.
// The receiver cannot stall; results are simply presented once.
// Reset clears the pipeline and restores the grid sizes to 64, the layer count
// to 2 and the orbital count to 1; busy is high for the cycle after reset.
// The grid contents are not cleared: a node must be written before it is read.
// Configuration writes on the csr_ port take effect at once and should be made
// while no query is in flight.
module periodic_bilinear_table_interpolator_top #(
   parameter int GRID_MAX      = 64,
   parameter int SAMPLE_BITS   = 24,
   parameter int POS_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_command,
   input  logic [5:0]                 req_node_x,
   input  logic [5:0]                 req_node_y,
   input  logic signed [23:0]         req_sample_x,
   input  logic signed [23:0]         req_sample_y,
   input  logic signed [23:0]         req_sample_z,
   input  logic [POS_FRAC_BITS-1:0]   req_pos_a,
   input  logic [POS_FRAC_BITS-1:0]   req_pos_b,
   input  logic [2:0]                 req_layer,
   input  logic [3:0]                 req_orbital,
   output logic                       rsp_valid,
   output logic signed [23:0]         rsp_disp_x_out,
   output logic signed [23:0]         rsp_disp_y_out,
   output logic signed [23:0]         rsp_disp_z_out,
   output logic [1:0]                 rsp_error_code,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [6:0]                 csr_wdata
);

   localparam int F     = POS_FRAC_BITS;
   localparam int SB    = SAMPLE_BITS;
   localparam int IW    = $clog2(GRID_MAX);
   localparam int GW    = IW + 1;
   localparam int ADW   = 2 * IW;
   localparam int DEPTH = 1 << ADW;
   localparam int SIZE_RST = (64 > GRID_MAX) ? GRID_MAX : 64;
   localparam logic signed [32:0] SMAX = 33'((64'sd1 <<< (SB - 1)) - 1);
   localparam logic signed [32:0] SMIN = 33'(-(64'sd1 <<< (SB - 1)));

   // Configuration registers.
   logic [GW-1:0] gsx_ff, gsy_ff, size_in;
   logic [3:0]    layers_ff;
   logic [4:0]    orbitals_ff;
   logic [9:0]    wd_ext;
   logic          busy_ff;

   assign wd_ext = {3'b000, csr_wdata};

   always_comb begin
      if (csr_wdata == 7'd0) begin
         size_in = GW'(1);
      end else if (wd_ext > 10'(GRID_MAX)) begin
         size_in = GW'(GRID_MAX);
      end else begin
         size_in = wd_ext[GW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gsx_ff      <= GW'(SIZE_RST);
         gsy_ff      <= GW'(SIZE_RST);
         layers_ff   <= 4'd2;
         orbitals_ff <= 5'd1;
         busy_ff     <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               pbti_pkg::REG_GRID_X:   gsx_ff      <= size_in;
               pbti_pkg::REG_GRID_Y:   gsy_ff      <= size_in;
               pbti_pkg::REG_LAYERS:   layers_ff   <= csr_wdata[3:0];
               pbti_pkg::REG_ORBITALS: orbitals_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
   end

   assign busy = busy_ff;

   logic accept;
   assign accept = start && !busy_ff;

   // Write path: goes straight into all four memory copies.
   logic [8:0]              nx_ext, ny_ext;
   logic                    wr_en;
   logic [ADW-1:0]          wr_addr;
   logic signed [32:0]      smp_ext [3];
   logic [SB-1:0]           smp_sat [3];
   logic [3*SB-1:0]         wr_data;

   assign nx_ext  = {3'b000, req_node_x};
   assign ny_ext  = {3'b000, req_node_y};
   assign wr_en   = accept && (req_command == pbti_pkg::CMD_WRITE)
                    && (nx_ext < 9'(GRID_MAX)) && (ny_ext < 9'(GRID_MAX));
   assign wr_addr = {nx_ext[IW-1:0], ny_ext[IW-1:0]};

   assign smp_ext[0] = {{9{req_sample_x[23]}}, req_sample_x};
   assign smp_ext[1] = {{9{req_sample_y[23]}}, req_sample_y};
   assign smp_ext[2] = {{9{req_sample_z[23]}}, req_sample_z};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (smp_ext[k] > SMAX) begin
            smp_sat[k] = SMAX[SB-1:0];
         end else if (smp_ext[k] < SMIN) begin
            smp_sat[k] = SMIN[SB-1:0];
         end else begin
            smp_sat[k] = smp_ext[k][SB-1:0];
         end
      end
   end

   assign wr_data = {smp_sat[2], smp_sat[1], smp_sat[0]};

   // Stage 1: registered query.
   logic               s1_valid_ff;
   logic [F-1:0]       pa_ff, pb_ff;
   logic [2:0]         layer_ff;
   logic [3:0]         orbital_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && (req_command == pbti_pkg::CMD_QUERY);
      end
      pa_ff      <= req_pos_a;
      pb_ff      <= req_pos_b;
      layer_ff   <= req_layer;
      orbital_ff <= req_orbital;
   end

   logic               neg;
   logic [F-1:0]       pa_m, pb_m;
   logic [F+GW-1:0]    sa, sb;
   logic [IW-1:0]      i0, i1, j0, j1;
   logic [IW:0]        i0p, j0p;
   logic [1:0]         err;
   pbti_pkg::ctl_type  ctl_in, ctl_ff;
   logic [F-1:0]       fx_ff, fy_ff;

   // Mirroring a nonzero coordinate to one minus it is a two's complement negation.
   assign neg  = (layer_ff == pbti_pkg::LAYER_MIRROR);
   assign pa_m = neg ? -pa_ff : pa_ff;
   assign pb_m = neg ? -pb_ff : pb_ff;
   assign sa   = pa_m * gsx_ff;
   assign sb   = pb_m * gsy_ff;
   assign i0   = sa[F+IW-1:F];
   assign j0   = sb[F+IW-1:F];
   assign i0p  = {1'b0, i0} + 1'b1;
   assign j0p  = {1'b0, j0} + 1'b1;
   assign i1   = (i0p == gsx_ff) ? '0 : i0p[IW-1:0];
   assign j1   = (j0p == gsy_ff) ? '0 : j0p[IW-1:0];

   always_comb begin
      if ({1'b0, layer_ff} >= layers_ff) begin
         err = pbti_pkg::ERR_LAYER;
      end else if ({1'b0, orbital_ff} >= orbitals_ff) begin
         err = pbti_pkg::ERR_ORBITAL;
      end else begin
         err = pbti_pkg::ERR_NONE;
      end
   end

   assign ctl_in = '{valid: s1_valid_ff, neg: neg, err: err};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      fx_ff <= sa[F-1:0];
      fy_ff <= sb[F-1:0];
   end

   // Four memory copies, one per corner.
   logic [3*SB-1:0] rd00, rd10, rd01, rd11;

   pbti_ram #(.WIDTH(3*SB), .DEPTH(DEPTH)) u_ram00 (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr({i0, j0}), .rd_data(rd00)
   );
   pbti_ram #(.WIDTH(3*SB), .DEPTH(DEPTH)) u_ram10 (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr({i1, j0}), .rd_data(rd10)
   );
   pbti_ram #(.WIDTH(3*SB), .DEPTH(DEPTH)) u_ram01 (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr({i0, j1}), .rd_data(rd01)
   );
   pbti_ram #(.WIDTH(3*SB), .DEPTH(DEPTH)) u_ram11 (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr({i1, j1}), .rd_data(rd11)
   );

   pbti_pkg::ctl_type out_ctl;

   pbti_blend #(.SB(SB), .F(F)) u_blend (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (ctl_ff),
      .fx      (fx_ff),
      .fy      (fy_ff),
      .c00     (rd00),
      .c10     (rd10),
      .c01     (rd01),
      .c11     (rd11),
      .out_ctl (out_ctl),
      .out_x   (rsp_disp_x_out),
      .out_y   (rsp_disp_y_out),
      .out_z   (rsp_disp_z_out)
   );

   assign rsp_valid      = out_ctl.valid;
   assign rsp_error_code = out_ctl.err;

   // Every result stems from an accepted query.
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_command == pbti_pkg::CMD_QUERY, 5))
      else $error("result without a matching query");

   // A write item never produces a result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == pbti_pkg::CMD_WRITE) |-> ##5 !rsp_valid)
      else $error("result produced for a write item");

   // An error result carries zero displacements.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != pbti_pkg::ERR_NONE) |->
         (rsp_disp_x_out == 0 && rsp_disp_y_out == 0 && rsp_disp_z_out == 0))
      else $error("error result with nonzero displacement");

endmodule
